/* rtl/core/pft_pkg.sv */
// Shared types, constants and the CORDIC arctangent table of the planar frame transform.
`default_nettype none
package pft_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int POSITION_BITS = 32;

    // Number of micro-rotations actually built; the arctangent table has 32 entries.
    localparam int STAGES_USED = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int STAGE_W     = $clog2(STAGES_USED);

    // Width of the position saturation range.
    localparam int POS_W = (POSITION_BITS < 32) ? POSITION_BITS : 32;

    // CORDIC datapath width: Q2.30 values with headroom for intermediate growth.
    localparam int CW = 34;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] Q30_ONE     = 34'sd1073741824;

    // Width of the position result before saturation: rounded product sum plus offset.
    localparam int RND_W = 36;
    localparam int SUM_W = 37;

    localparam logic signed [SUM_W-1:0] POS_HI = SUM_W'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] POS_LO = -POS_HI - SUM_W'(1);

    typedef enum logic {
        ACT_WORLD_TO_LOCAL = 1'b0,
        ACT_LOCAL_TO_WORLD = 1'b1
    } t_action;

    typedef struct packed {
        logic               action;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [15:0] pose_heading;
        logic signed [31:0] ref_x;
        logic signed [31:0] ref_y;
        logic signed [15:0] ref_heading;
    } t_req;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [15:0] out_heading;
        logic               saturated;
    } t_res;

    // Request fields that ride along the rotation pipeline.
    typedef struct packed {
        logic               action;
        logic               flip;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [31:0] ref_x;
        logic signed [31:0] ref_y;
        logic signed [15:0] heading;
    } t_item;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        t_item                item;
    } t_cell;

    // Arctangent of 2^-idx as a 32-bit binary angle.
    function automatic logic [31:0] atan_angle(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/pft_req_if.sv */
// Request channel interface of the planar frame transform.
`default_nettype none
interface pft_req_if;
    import pft_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/pft_res_if.sv */
// Result channel interface of the planar frame transform.
`default_nettype none
interface pft_res_if;
    import pft_pkg::*;

    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/planar_frame_transform_top.sv */
// Top level of the planar frame transform: CORDIC cell chain followed by the combine stages.
`default_nettype none
// Transforms a planar pose between a reference frame and the world. Every request gives
// exactly one result, in request order. The block takes one request per cycle while the
// pipeline does not stall. Each request runs through one cell per micro-rotation of the
// CORDIC chain that forms the sine and cosine of the reference heading, then five stages for
// the clip, the multipliers, the sums, the rounding and the offset with saturation. Every
// stage moves on when the stage after it is empty or moving, so requests keep being taken
// into free stages while a finished result waits at the output. The block holds no state
// beyond the pipeline and needs no setup after reset.
module planar_frame_transform_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pft_req_if.sink    i_req,
    pft_res_if.source  o_res
);
    import pft_pkg::*;

    logic  w_vld [STAGES_USED+1];
    t_cell w_cell [STAGES_USED+1];
    logic  w_en [STAGES_USED+1];
    logic  post_ready;
    logic  flip;
    logic [15:0] z_hi;
    t_cell init;

    // Headings outside the right half plane are turned by a half turn before the rotation.
    always_comb begin
        flip = i_req.data.ref_heading[15] ^ i_req.data.ref_heading[14];
        z_hi = i_req.data.ref_heading ^ {flip, 15'b0};
        init.x = CORDIC_GAIN;
        init.y = '0;
        init.z = CW'($signed({z_hi, 16'b0}));
        init.item.action  = i_req.data.action;
        init.item.flip    = flip;
        init.item.pose_x  = i_req.data.pose_x;
        init.item.pose_y  = i_req.data.pose_y;
        init.item.ref_x   = i_req.data.ref_x;
        init.item.ref_y   = i_req.data.ref_y;
        if (i_req.data.action == ACT_LOCAL_TO_WORLD) begin
            init.item.heading = i_req.data.pose_heading + i_req.data.ref_heading;
        end else begin
            init.item.heading = i_req.data.pose_heading - i_req.data.ref_heading;
        end
    end

    assign w_vld[0]            = i_req.valid;
    assign w_cell[0]           = init;
    assign w_en[STAGES_USED]   = post_ready;
    assign i_req.ready         = w_en[0];

    for (genvar g = 0; g < STAGES_USED; g++) begin : g_cell
        assign w_en[g] = ~w_vld[g+1] | w_en[g+1];

        pft_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en[g]),
            .i_stage (STAGE_W'(g)),
            .i_valid (w_vld[g]),
            .i_cell  (w_cell[g]),
            .o_valid (w_vld[g+1]),
            .o_cell  (w_cell[g+1])
        );
    end

    pft_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_vld[STAGES_USED]),
        .i_cell  (w_cell[STAGES_USED]),
        .o_ready (post_ready),
        .o_valid (o_res.valid),
        .o_res   (o_res.data),
        .i_ready (o_res.ready)
    );
endmodule
`default_nettype wire

/* rtl/core/pft_cordic_cell.sv */
// One CORDIC micro-rotation cell of the rotation pipeline.
`default_nettype none
module pft_cordic_cell (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic [pft_pkg::STAGE_W-1:0] i_stage,
    input  wire logic                   i_valid,
    input  wire pft_pkg::t_cell         i_cell,
    output logic                        o_valid,
    output pft_pkg::t_cell              o_cell
);
    import pft_pkg::*;

    logic              r_valid;
    t_cell             r_cell;
    t_cell             n_cell;
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [CW-1:0] z_in;
    logic signed [CW-1:0] x_shr;
    logic signed [CW-1:0] y_shr;
    logic signed [CW-1:0] step;

    always_comb begin
        x_in  = i_cell.x;
        y_in  = i_cell.y;
        z_in  = i_cell.z;
        x_shr = x_in >>> i_stage;
        y_shr = y_in >>> i_stage;
        step  = $signed({{(CW-32){1'b0}}, atan_angle(5'(i_stage))});
        n_cell = i_cell;
        if (!z_in[CW-1]) begin
            n_cell.x = x_in - y_shr;
            n_cell.y = y_in + x_shr;
            n_cell.z = z_in - step;
        end else begin
            n_cell.x = x_in + y_shr;
            n_cell.y = y_in - x_shr;
            n_cell.z = z_in + step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;
endmodule
`default_nettype wire

/* rtl/core/pft_combine.sv */
// Applies sine and cosine to the position, rounds, offsets and saturates the result.
`default_nettype none
module pft_combine (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire pft_pkg::t_cell i_cell,
    output logic                o_ready,
    output logic                o_valid,
    output pft_pkg::t_res       o_res,
    input  wire logic           i_ready
);
    import pft_pkg::*;

    localparam int NSTG = 5;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    // Stage 0: sine and cosine, position operands.
    logic signed [31:0] r_c, r_s;
    logic signed [32:0] r_a, r_b;
    // Stage 1: products.
    logic signed [64:0] r_ca, r_sb, r_cb, r_sa;
    // Stage 2: product sums.
    logic signed [65:0] r_sum_x, r_sum_y;
    // Stage 3: rounded to Q16.16.
    logic signed [RND_W-1:0] r_rnd_x, r_rnd_y;
    // Stage 4: output register.
    t_res r_res;

    logic [NSTG-2:0] r_act;
    logic signed [31:0] r_rx [NSTG-1];
    logic signed [31:0] r_ry [NSTG-1];
    logic signed [15:0] r_hd [NSTG-1];

    logic signed [CW-1:0] cx, cy;
    logic signed [31:0]   n_c, n_s;
    logic signed [32:0]   n_a, n_b;
    logic signed [SUM_W-1:0] vx, vy;
    logic                 sat_x, sat_y;
    t_res                 n_res;

    always_comb begin
        en[NSTG-1] = ~r_vld[NSTG-1] | i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = ~r_vld[k] | en[k+1];
        end
    end

    assign o_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Undo the half turn taken before the rotation and clip to plus or minus one.
    always_comb begin
        cx = i_cell.item.flip ? -i_cell.x : i_cell.x;
        cy = i_cell.item.flip ? -i_cell.y : i_cell.y;
        if (cx > Q30_ONE) begin
            n_c = 32'sd1073741824;
        end else if (cx < -Q30_ONE) begin
            n_c = -32'sd1073741824;
        end else begin
            n_c = cx[31:0];
        end
        if (cy > Q30_ONE) begin
            n_s = 32'sd1073741824;
        end else if (cy < -Q30_ONE) begin
            n_s = -32'sd1073741824;
        end else begin
            n_s = cy[31:0];
        end
        if (i_cell.item.action == ACT_LOCAL_TO_WORLD) begin
            n_a = 33'(i_cell.item.pose_x);
            n_b = 33'(i_cell.item.pose_y);
        end else begin
            n_a = 33'(i_cell.item.pose_x) - 33'(i_cell.item.ref_x);
            n_b = 33'(i_cell.item.pose_y) - 33'(i_cell.item.ref_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_c      <= n_c;
            r_s      <= n_s;
            r_a      <= n_a;
            r_b      <= n_b;
            r_act[0] <= i_cell.item.action;
            r_rx[0]  <= i_cell.item.ref_x;
            r_ry[0]  <= i_cell.item.ref_y;
            r_hd[0]  <= i_cell.item.heading;
        end
        if (en[1]) begin
            r_ca     <= r_c * r_a;
            r_sb     <= r_s * r_b;
            r_cb     <= r_c * r_b;
            r_sa     <= r_s * r_a;
        end
        if (en[2]) begin
            if (r_act[1] == ACT_LOCAL_TO_WORLD) begin
                r_sum_x <= 66'(r_ca) - 66'(r_sb);
                r_sum_y <= 66'(r_sa) + 66'(r_cb);
            end else begin
                r_sum_x <= 66'(r_ca) + 66'(r_sb);
                r_sum_y <= 66'(r_cb) - 66'(r_sa);
            end
        end
        if (en[3]) begin
            r_rnd_x <= RND_W'((r_sum_x + 66'sd536870912) >>> 30);
            r_rnd_y <= RND_W'((r_sum_y + 66'sd536870912) >>> 30);
        end
        for (int k = 1; k < NSTG - 1; k++) begin
            if (en[k]) begin
                r_act[k] <= r_act[k-1];
                r_rx[k]  <= r_rx[k-1];
                r_ry[k]  <= r_ry[k-1];
                r_hd[k]  <= r_hd[k-1];
            end
        end
        if (en[4]) begin
            r_res <= n_res;
        end
    end

    // Add the reference origin when going to the world frame, then saturate.
    always_comb begin
        vx = SUM_W'(r_rnd_x);
        vy = SUM_W'(r_rnd_y);
        if (r_act[3] == ACT_LOCAL_TO_WORLD) begin
            vx = vx + SUM_W'(r_rx[3]);
            vy = vy + SUM_W'(r_ry[3]);
        end
        sat_x = 1'b1;
        sat_y = 1'b1;
        if (vx > POS_HI) begin
            n_res.out_x = POS_HI[31:0];
        end else if (vx < POS_LO) begin
            n_res.out_x = POS_LO[31:0];
        end else begin
            n_res.out_x = vx[31:0];
            sat_x       = 1'b0;
        end
        if (vy > POS_HI) begin
            n_res.out_y = POS_HI[31:0];
        end else if (vy < POS_LO) begin
            n_res.out_y = POS_LO[31:0];
        end else begin
            n_res.out_y = vy[31:0];
            sat_y       = 1'b0;
        end
        n_res.out_heading = r_hd[3];
        n_res.saturated   = sat_x | sat_y;
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_res   = r_res;
endmodule
`default_nettype wire

/* tb/planar_frame_transform_top_tb.sv */
// Self-checking testbench of the planar frame transform: directed and randomized poses against a predictor.
module planar_frame_transform_top_tb;
    import pft_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 40;

    // Expected poses in request order, with the predictor that produces them.
    class pose_ledger;
        pft_pkg::t_res poses_due[$];
        int            mismatches = 0;

        function automatic void heading_cos_sin(input logic [15:0] heading,
                                                output longint cos_q30,
                                                output longint sin_q30);
            logic [31:0] atan_bam [32];
            logic [31:0] ang;
            bit          flip;
            longint      cx, sy, zr, xs, ys, unit;
            int          stages;
            atan_bam = '{
                32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
                32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
                32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
            };
            stages = (pft_pkg::CORDIC_STAGES > 32) ? 32 : pft_pkg::CORDIC_STAGES;
            unit   = 64'sd1073741824;
            ang    = {heading, 16'h0000};
            // Angles in the left half plane are turned by pi and the results negated.
            flip   = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
            if (flip) ang = ang + 32'h80000000;
            zr = longint'($signed(ang));
            cx = 64'sd652032874;
            sy = 0;
            for (int i = 0; i < stages; i++) begin
                xs = cx >>> i;
                ys = sy >>> i;
                if (zr >= 0) begin
                    cx = cx - ys;
                    sy = sy + xs;
                    zr = zr - longint'(atan_bam[i]);
                end else begin
                    cx = cx + ys;
                    sy = sy - xs;
                    zr = zr + longint'(atan_bam[i]);
                end
            end
            if (flip) begin
                cx = -cx;
                sy = -sy;
            end
            if (cx > unit) cx = unit;
            if (cx < -unit) cx = -unit;
            if (sy > unit) sy = unit;
            if (sy < -unit) sy = -unit;
            cos_q30 = cx;
            sin_q30 = sy;
        endfunction

        function automatic pft_pkg::t_res transform_pose(input pft_pkg::t_req rq);
            pft_pkg::t_res      rs;
            longint             c, s;
            logic signed [79:0] cw, sw, px, py, rx, ry, dx, dy, ox, oy, half, hi, lo;
            int                 pos_w;
            heading_cos_sin(rq.ref_heading, c, s);
            cw   = c;
            sw   = s;
            px   = rq.pose_x;
            py   = rq.pose_y;
            rx   = rq.ref_x;
            ry   = rq.ref_y;
            half = 80'sd536870912;
            if (rq.action == pft_pkg::ACT_WORLD_TO_LOCAL) begin
                dx = px - rx;
                dy = py - ry;
                ox = (cw * dx + sw * dy + half) >>> 30;
                oy = (cw * dy - sw * dx + half) >>> 30;
                rs.out_heading = rq.pose_heading - rq.ref_heading;
            end else begin
                // Rounding happens before the reference offset is added.
                ox = ((cw * px - sw * py + half) >>> 30) + rx;
                oy = ((sw * px + cw * py + half) >>> 30) + ry;
                rs.out_heading = rq.pose_heading + rq.ref_heading;
            end
            pos_w = (pft_pkg::POSITION_BITS < 32) ? pft_pkg::POSITION_BITS : 32;
            hi = (80'sd1 <<< (pos_w - 1)) - 80'sd1;
            lo = -hi - 80'sd1;
            rs.saturated = 1'b0;
            if (ox > hi) begin
                ox = hi;
                rs.saturated = 1'b1;
            end else if (ox < lo) begin
                ox = lo;
                rs.saturated = 1'b1;
            end
            if (oy > hi) begin
                oy = hi;
                rs.saturated = 1'b1;
            end else if (oy < lo) begin
                oy = lo;
                rs.saturated = 1'b1;
            end
            rs.out_x = ox[31:0];
            rs.out_y = oy[31:0];
            return rs;
        endfunction

        function void note_request(input pft_pkg::t_req rq);
            poses_due.push_back(transform_pose(rq));
        endfunction

        function void check_result(input pft_pkg::t_res got);
            pft_pkg::t_res want;
            if (poses_due.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected pose result: x=%h y=%h hdg=%h sat=%b",
                             got.out_x, got.out_y, got.out_heading, got.saturated);
                mismatches++;
                return;
            end
            want = poses_due.pop_front();
            if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
                    got.out_heading !== want.out_heading || got.saturated !== want.saturated) begin
                if (mismatches < 10)
                    $display({"pose mismatch: expected x=%h y=%h hdg=%h sat=%b, ",
                              "got x=%h y=%h hdg=%h sat=%b"},
                             want.out_x, want.out_y, want.out_heading, want.saturated,
                             got.out_x, got.out_y, got.out_heading, got.saturated);
                mismatches++;
            end
        endfunction

        function int pending();
            return poses_due.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    bit         rx_free_run;
    bit         rx_hold_req;
    bit         tx_gaps_on;
    pose_ledger ledger;

    pft_req_if req_ch ();
    pft_res_if res_ch ();

    planar_frame_transform_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned idle_cycles();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [31:0] random_position();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $signed($urandom_range(0, 33554431)) - 32'sd16777216;
            7:          return $signed($urandom_range(0, 2147483647)) - 32'sd1073741824;
            8:          return 32'sh7FFFFFFF - $urandom_range(0, 3);
            default:    return 32'sh80000000 + $urandom_range(0, 3);
        endcase
    endfunction

    // Mostly uniform headings, some close to the multiples of an eighth turn.
    function automatic logic signed [15:0] random_heading();
        if ($urandom_range(0, 5) == 0)
            return 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 2) - 1);
        return 16'($urandom);
    endfunction

    function automatic t_req random_request();
        t_req rq;
        rq.action       = 1'($urandom_range(0, 1));
        rq.pose_x       = random_position();
        rq.pose_y       = random_position();
        rq.pose_heading = random_heading();
        rq.ref_x        = random_position();
        rq.ref_y        = random_position();
        rq.ref_heading  = random_heading();
        return rq;
    endfunction

    function automatic t_req make_request(input t_action act,
                                          input logic signed [31:0] px, py,
                                          input logic signed [15:0] ph,
                                          input logic signed [31:0] rx, ry,
                                          input logic signed [15:0] rh);
        t_req rq;
        rq.action       = act;
        rq.pose_x       = px;
        rq.pose_y       = py;
        rq.pose_heading = ph;
        rq.ref_x        = rx;
        rq.ref_y        = ry;
        rq.ref_heading  = rh;
        return rq;
    endfunction

    task automatic offer_request(input t_req rq);
        req_ch.valid <= 1'b1;
        req_ch.data  <= rq;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat (idle_cycles()) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_poses();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (ledger.pending() != 0);
    endtask

    // Accepted requests and results are both observed here so their order is fixed.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
                ledger.note_request(req_ch.data);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
                ledger.check_result(res_ch.data);
        end
    end

    initial begin
        res_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else if (rx_free_run || $urandom_range(0, 3) != 0) begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b0;
                repeat (idle_cycles()) @(posedge i_clk);
            end
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("planar_frame_transform_top_tb: FAIL");
        $finish;
    end

    initial begin
        t_req directed[$];
        ledger       = new;
        rx_free_run  = 1'b0;
        rx_hold_req  = 1'b0;
        tx_gaps_on   = 1'b1;
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back(make_request(ACT_WORLD_TO_LOCAL, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_request(ACT_LOCAL_TO_WORLD, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_request(ACT_WORLD_TO_LOCAL, 65536, 0, 0, 0, 0, 16384));
        directed.push_back(make_request(ACT_LOCAL_TO_WORLD, 65536, 131072, 100,
                                        -65536, 0, -16384));
        // Position extremes that clip high, low and on both axes.
        directed.push_back(make_request(ACT_WORLD_TO_LOCAL, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                        32767, 32'sh80000000, 32'sh80000000, 0));
        directed.push_back(make_request(ACT_WORLD_TO_LOCAL, 32'sh80000000, 32'sh80000000,
                                        -32768, 32'sh7FFFFFFF, 32'sh7FFFFFFF, -32768));
        directed.push_back(make_request(ACT_LOCAL_TO_WORLD, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                        32767, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1));
        directed.push_back(make_request(ACT_LOCAL_TO_WORLD, 32'sh80000000, 32'sh80000000,
                                        -32768, 32'sh80000000, 32'sh80000000, -1));
        // Heading difference that wraps past pi.
        directed.push_back(make_request(ACT_WORLD_TO_LOCAL, 12345678, -7654321, 32767,
                                        0, 0, -1));
        directed.push_back(make_request(ACT_WORLD_TO_LOCAL, 32'sh7FFFFFFF, 0, 0, 0, 0, 8192));
        directed.push_back(make_request(ACT_LOCAL_TO_WORLD, 32'sh7FFFFFFF, 32'sh80000000,
                                        0, 0, 0, -8192));
        directed.push_back(make_request(ACT_WORLD_TO_LOCAL, -1, 1, 0, 1, -1, 32767));
        // Reference headings on either side of the half-plane turn.
        directed.push_back(make_request(ACT_LOCAL_TO_WORLD, 1, 1, 0, 0, 0, 16383));
        directed.push_back(make_request(ACT_LOCAL_TO_WORLD, 1048576, -1048576, 0,
                                        0, 0, -16385));
        directed.push_back(make_request(ACT_WORLD_TO_LOCAL, 0, 0, 0, 32'sh7FFFFFFF,
                                        32'sh80000000, 24576));
        directed.push_back(make_request(ACT_LOCAL_TO_WORLD, 32'sh40000000, 32'sh40000000,
                                        -16384, 32'sh40000000, 32'sh40000000, 0));
        directed.push_back(make_request(ACT_WORLD_TO_LOCAL, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                        0, -1, -1, 0));
        directed.push_back(make_request(ACT_LOCAL_TO_WORLD, 0, 0, -32768, 32'sh80000000,
                                        32'sh7FFFFFFF, -32768));
        foreach (directed[k])
            offer_request(directed[k]);
        wait_all_poses();

        for (int blk = 0; blk < 6; blk++) begin
            rx_free_run = (blk == 1);
            tx_gaps_on  = (blk != 1);
            if (blk == 3) begin
                // The result side holds off while requests keep coming back to back.
                rx_hold_req = 1'b1;
                tx_gaps_on  = 1'b0;
            end
            for (int n = 0; n < 300; n++) begin
                if (blk == 3 && n == 100)
                    tx_gaps_on = 1'b1;
                offer_request(random_request());
            end
            if (blk == 2)
                wait_all_poses();
        end
        rx_free_run = 1'b0;
        wait_all_poses();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("planar_frame_transform_top_tb: PASS");
        else
            $display("planar_frame_transform_top_tb: FAIL");
        $finish;
    end
endmodule

/* sim.f */
rtl/core/pft_pkg.sv
rtl/core/pft_req_if.sv
rtl/core/pft_res_if.sv
rtl/core/pft_cordic_cell.sv
rtl/core/pft_combine.sv
rtl/core/planar_frame_transform_top.sv
tb/planar_frame_transform_top_tb.sv
